// ===== rtl/cirm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cirm_pkg
// Shared codes and constants for the contiguous ID range map.
// ----------------------------------------------------------------------------
package cirm_pkg;

   localparam int TAG_BITS = 16;
   localparam int FIELD_ID_BITS = 32;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_IN_USE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_GAP       = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

endpackage

// ===== rtl/cirm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cirm_cell
// One table entry plus one stage of the search token path.
// ----------------------------------------------------------------------------
module cirm_cell
   import cirm_pkg::*;
#(
   parameter int MAX_ENTRIES = 256,
   parameter int ID_BITS     = 32,
   parameter int IDX         = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] count_i,
   input  logic [$clog2(MAX_ENTRIES+1)+2*ID_BITS+TAG_BITS+1:0] wr_i,
   input  logic [3*ID_BITS+2*TAG_BITS+2:0] tok_i,
   output logic [3*ID_BITS+2*TAG_BITS+2:0] tok_o
);

   localparam int CW = $clog2(MAX_ENTRIES+1);

   typedef struct packed {
      logic                en;
      logic                ext;     // extend end of existing entry only
      logic [CW-1:0]       idx;
      logic [ID_BITS-1:0]  first;
      logic [ID_BITS-1:0]  last;
      logic [TAG_BITS-1:0] tag;
   } wr_type;

   typedef struct packed {
      logic                valid;
      logic                lookup;
      logic [ID_BITS-1:0]  key;
      logic [TAG_BITS-1:0] tag;
      logic                hit;
      logic [TAG_BITS-1:0] ftype;
      logic [ID_BITS-1:0]  fstart;
      logic [ID_BITS-1:0]  fend;
   } tok_type;

   wr_type  wr;
   tok_type tin;
   tok_type tok_in;
   tok_type tok_ff;

   logic [ID_BITS-1:0]  start_ff;
   logic [ID_BITS-1:0]  end_ff;
   logic [TAG_BITS-1:0] type_ff;
   logic                take;
   logic                sel;

   assign wr  = wr_type'(wr_i);
   assign tin = tok_type'(tok_i);
   assign sel = wr.en && (wr.idx == CW'(IDX));

   always_ff @(posedge clock) begin
      if (sel) begin
         end_ff <= wr.last;
         if (!wr.ext) begin
            start_ff <= wr.first;
            type_ff  <= wr.tag;
         end
      end
   end

   always_comb begin
      take = tin.valid && !tin.hit && (CW'(IDX) < count_i) &&
             (tin.lookup ? ((tin.key >= start_ff) && (tin.key <= end_ff))
                         : (type_ff == tin.tag));
      tok_in = tin;
      if (take) begin
         tok_in.hit    = 1'b1;
         tok_in.ftype  = type_ff;
         tok_in.fstart = start_ff;
         tok_in.fend   = end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

// ===== rtl/cirm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cirm_ctrl
// Command sequencer: appends and clears, launches search tokens, result reg.
// ----------------------------------------------------------------------------
module cirm_ctrl
   import cirm_pkg::*;
#(
   parameter int MAX_ENTRIES = 256,
   parameter int ID_BITS     = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_type_tag,
   input  logic [31:0] req_range_start,
   input  logic [31:0] req_range_end,
   input  logic [31:0] req_query_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_found_type,
   output logic [31:0] rsp_found_start,
   output logic [31:0] rsp_found_end,
   output logic        rsp_in_use,
   output logic [$clog2(MAX_ENTRIES+1)-1:0] count_o,
   output logic [$clog2(MAX_ENTRIES+1)+2*ID_BITS+TAG_BITS+1:0] wr_o,
   output logic [3*ID_BITS+2*TAG_BITS+2:0] tok_o,
   input  logic [3*ID_BITS+2*TAG_BITS+2:0] tok_i
);

   localparam int CW = $clog2(MAX_ENTRIES+1);

   typedef struct packed {
      logic                en;
      logic                ext;
      logic [CW-1:0]       idx;
      logic [ID_BITS-1:0]  first;
      logic [ID_BITS-1:0]  last;
      logic [TAG_BITS-1:0] tag;
   } wr_type;

   typedef struct packed {
      logic                valid;
      logic                lookup;
      logic [ID_BITS-1:0]  key;
      logic [TAG_BITS-1:0] tag;
      logic                hit;
      logic [TAG_BITS-1:0] ftype;
      logic [ID_BITS-1:0]  fstart;
      logic [ID_BITS-1:0]  fend;
   } tok_type;

   typedef struct packed {
      status_type          status;
      logic [TAG_BITS-1:0] ftype;
      logic [ID_BITS-1:0]  fstart;
      logic [ID_BITS-1:0]  fend;
      logic                in_use;
   } res_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [ID_BITS-1:0]  last_ff, last_in;
   logic [TAG_BITS-1:0] last_type_ff, last_type_in;
   res_type             res_ff, res_in;
   res_type             out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   tok_type             tok_ff, tok_in;
   wr_type              wr_ff, wr_in;
   tok_type             tret;

   logic [ID_BITS-1:0]  s_id, e_id, q_id;
   logic                accept;
   logic                load_out;

   assign tret   = tok_type'(tok_i);
   assign s_id   = ID_BITS'(req_range_start);
   assign e_id   = ID_BITS'(req_range_end);
   assign q_id   = ID_BITS'(req_query_id);
   assign accept = req_valid && req_ready;
   assign load_out = (state_ff == ST_HOLD) && (!out_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_ff      <= '0;
         out_valid_ff <= 1'b0;
         tok_ff.valid <= 1'b0;
         wr_ff.en     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
         tok_ff       <= tok_in;
         wr_ff        <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      last_type_ff <= last_type_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      last_type_in = last_type_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      req_ready    = (state_ff == ST_IDLE);

      tok_in        = tok_ff;
      tok_in.valid  = 1'b0;
      wr_in         = wr_ff;
      wr_in.en      = 1'b0;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_in       = res_ff;
         out_valid_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in        = '0;
               res_in.status = STATUS_OK;
               case (cmd_type'(req_command))
                  CMD_ADD: begin
                     state_in    = ST_HOLD;
                     wr_in.first = s_id;
                     wr_in.last  = e_id;
                     wr_in.tag   = req_type_tag;
                     wr_in.ext   = 1'b0;
                     wr_in.idx   = count_ff;
                     if (e_id < s_id) begin
                        res_in.status = STATUS_GAP;
                     end else if (count_ff == '0) begin
                        wr_in.en     = 1'b1;
                        count_in     = CW'(1);
                        last_in      = e_id;
                        last_type_in = req_type_tag;
                     end else if ((&last_ff) || (s_id != last_ff + ID_BITS'(1))) begin
                        // id space does not wrap
                        res_in.status = STATUS_GAP;
                     end else if (req_type_tag == last_type_ff) begin
                        wr_in.en  = 1'b1;
                        wr_in.ext = 1'b1;
                        wr_in.idx = count_ff - CW'(1);
                        last_in   = e_id;
                     end else if (count_ff == CW'(MAX_ENTRIES)) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        wr_in.en     = 1'b1;
                        count_in     = count_ff + CW'(1);
                        last_in      = e_id;
                        last_type_in = req_type_tag;
                     end
                  end
                  CMD_LOOKUP, CMD_IN_USE: begin
                     state_in      = ST_SCAN;
                     tok_in.valid  = 1'b1;
                     tok_in.lookup = (cmd_type'(req_command) == CMD_LOOKUP);
                     tok_in.key    = q_id;
                     tok_in.tag    = req_type_tag;
                     tok_in.hit    = 1'b0;
                  end
                  default: begin
                     state_in = ST_HOLD;
                     count_in = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (tret.valid) begin
               state_in = ST_HOLD;
               res_in   = '0;
               if (tret.lookup) begin
                  res_in.status = tret.hit ? STATUS_OK : STATUS_NOT_FOUND;
                  if (tret.hit) begin
                     res_in.ftype  = tret.ftype;
                     res_in.fstart = tret.fstart;
                     res_in.fend   = tret.fend;
                  end
               end else begin
                  res_in.status = STATUS_OK;
                  res_in.in_use = tret.hit;
               end
            end
         end
         ST_HOLD: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign count_o = count_ff;
   assign wr_o    = wr_ff;
   assign tok_o   = tok_ff;

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_found_type  = out_ff.ftype;
   assign rsp_found_start = FIELD_ID_BITS'(out_ff.fstart);
   assign rsp_found_end   = FIELD_ID_BITS'(out_ff.fend);
   assign rsp_in_use      = out_ff.in_use;

endmodule

// ===== rtl/contiguous_id_range_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_id_range_map
// Table of ascending, contiguous ID ranges with type tags.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Add and clear register their result and
// wait in the hold state until the output register takes it. Look-up and
// type-in-use send a search token down a row of MAX_ENTRIES cells, one cell per
// cycle, and register the result that the last cell returns. A new transaction
// is accepted while the previous result still waits in the output register.
// Entries hold no reset value; only entries below the fill count are matched.
module contiguous_id_range_map
   import cirm_pkg::*;
#(
   parameter int MAX_ENTRIES = 256,
   parameter int ID_BITS     = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_type_tag,
   input  logic [31:0] req_range_start,
   input  logic [31:0] req_range_end,
   input  logic [31:0] req_query_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_found_type,
   output logic [31:0] rsp_found_start,
   output logic [31:0] rsp_found_end,
   output logic        rsp_in_use
);

   localparam int CW = $clog2(MAX_ENTRIES+1);
   localparam int WW = CW + 2*ID_BITS + TAG_BITS + 2;
   localparam int TW = 3*ID_BITS + 2*TAG_BITS + 3;

   logic [CW-1:0] count;
   logic [WW-1:0] wr;
   logic [TW-1:0] tok [0:MAX_ENTRIES];

   cirm_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ID_BITS     (ID_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_type_tag    (req_type_tag),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_query_id    (req_query_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_type  (rsp_found_type),
      .rsp_found_start (rsp_found_start),
      .rsp_found_end   (rsp_found_end),
      .rsp_in_use      (rsp_in_use),
      .count_o         (count),
      .wr_o            (wr),
      .tok_o           (tok[0]),
      .tok_i           (tok[MAX_ENTRIES])
   );

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      cirm_cell #(
         .MAX_ENTRIES (MAX_ENTRIES),
         .ID_BITS     (ID_BITS),
         .IDX         (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .count_i (count),
         .wr_i    (wr),
         .tok_i   (tok[g]),
         .tok_o   (tok[g+1])
      );
   end

endmodule

// ===== rtl/cirm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cirm_checker
// Port-level checks for the contiguous ID range map.
// ----------------------------------------------------------------------------
module cirm_checker
   import cirm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_found_type,
   input logic [31:0] rsp_found_start,
   input logic [31:0] rsp_found_end,
   input logic        rsp_in_use
);

   // stalled response transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_NOT_FOUND || rsp_status == STATUS_GAP ||
                    rsp_status == STATUS_FULL)
      |-> (rsp_found_type == '0) && (rsp_found_start == '0) && (rsp_found_end == '0))
      else $error("found fields set on failed transaction");

   a_in_use_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_use |-> (rsp_status == STATUS_OK) && (rsp_found_type == '0))
      else $error("in_use with bad status or found data");

   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) && (rsp_found_type != '0)
      |-> rsp_found_start <= rsp_found_end)
      else $error("found range reversed");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind contiguous_id_range_map cirm_checker u_cirm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_found_type  (rsp_found_type),
   .rsp_found_start (rsp_found_start),
   .rsp_found_end   (rsp_found_end),
   .rsp_in_use      (rsp_in_use)
);

// ===== verif/tb_contiguous_id_range_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_id_range_map
// Self-checking bench for the contiguous ID range map. Transactions are
// predicted by a table model held in the bench and results are compared
// field by field, in order; both handshakes idle at random except in the first random test.
// ----------------------------------------------------------------------------
module tb_contiguous_id_range_map;
   import cirm_pkg::*;

   localparam int MAP_DEPTH = 256;
   localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      cmd_type     cmd;
      status_type  status;
      logic [15:0] found_type;
      logic [31:0] found_start;
      logic [31:0] found_end;
      logic        in_use;
   } map_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = 2'd0;
   logic [15:0] req_type_tag = 16'd0;
   logic [31:0] req_range_start = 32'd0;
   logic [31:0] req_range_end = 32'd0;
   logic [31:0] req_query_id = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_found_type;
   logic [31:0] rsp_found_start;
   logic [31:0] rsp_found_end;
   logic        rsp_in_use;

   // bench copy of the range table
   logic [31:0] tbl_start [MAP_DEPTH];
   logic [31:0] tbl_end [MAP_DEPTH];
   logic [15:0] tbl_type [MAP_DEPTH];
   int          tbl_count = 0;
   logic [31:0] span_lo = 32'd0;
   logic [31:0] span_hi = 32'd0;

   map_result_type pending_results [$];
   logic [15:0] tag_pool [8];
   int          error_count = 0;
   bit          sender_idles = 1'b1;
   bit          receiver_idles = 1'b1;

   contiguous_id_range_map #(
      .MAX_ENTRIES(MAP_DEPTH),
      .ID_BITS(32)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_type_tag(req_type_tag),
      .req_range_start(req_range_start),
      .req_range_end(req_range_end),
      .req_query_id(req_query_id),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found_type(rsp_found_type),
      .rsp_found_start(rsp_found_start),
      .rsp_found_end(rsp_found_end),
      .rsp_in_use(rsp_in_use)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_contiguous_id_range_map failed");
      $finish;
   end

   // Applies one transaction to the table copy and returns what the block owes.
   function automatic map_result_type predict_map_result(cmd_type cmd, logic [15:0] tag,
                                                          logic [31:0] s, logic [31:0] e,
                                                          logic [31:0] q);
      map_result_type res;
      res = '0;
      res.cmd = cmd;
      res.status = STATUS_OK;
      case (cmd)
         CMD_ADD: begin
            if (e < s) begin
               res.status = STATUS_GAP;
            end else if (tbl_count == 0) begin
               tbl_start[0] = s;
               tbl_end[0] = e;
               tbl_type[0] = tag;
               tbl_count = 1;
               span_lo = s;
               span_hi = e;
            end else if (span_hi == ID_MAX || s != span_hi + 32'd1) begin
               res.status = STATUS_GAP;
            end else if (tbl_type[tbl_count - 1] == tag) begin
               // same type as the tail entry: grow it, allowed even when full
               tbl_end[tbl_count - 1] = e;
               span_hi = e;
            end else if (tbl_count >= MAP_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               tbl_start[tbl_count] = s;
               tbl_end[tbl_count] = e;
               tbl_type[tbl_count] = tag;
               tbl_count++;
               span_hi = e;
            end
         end
         CMD_LOOKUP: begin
            res.status = STATUS_NOT_FOUND;
            if (tbl_count != 0 && q >= span_lo && q <= span_hi) begin
               for (int i = 0; i < tbl_count; i++) begin
                  if (q >= tbl_start[i] && q <= tbl_end[i]) begin
                     res.status = STATUS_OK;
                     res.found_type = tbl_type[i];
                     res.found_start = tbl_start[i];
                     res.found_end = tbl_end[i];
                     break;
                  end
               end
            end
         end
         CMD_IN_USE: begin
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_type[i] == tag) begin
                  res.in_use = 1'b1;
                  break;
               end
            end
         end
         default: begin
            // clear drops the count only; span bounds stay stale
            tbl_count = 0;
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= 50)
         $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
   endtask

   task automatic check_result;
      map_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result with nothing pending, status", 32'(rsp_status), 32'd0);
      end else begin
         want = pending_results.pop_front();
         if (rsp_status !== want.status)
            report_mismatch({want.cmd.name(), " status"}, 32'(rsp_status), 32'(want.status));
         if (rsp_found_type !== want.found_type)
            report_mismatch({want.cmd.name(), " found_type"}, 32'(rsp_found_type),
                            32'(want.found_type));
         if (rsp_found_start !== want.found_start)
            report_mismatch({want.cmd.name(), " found_start"}, rsp_found_start,
                            want.found_start);
         if (rsp_found_end !== want.found_end)
            report_mismatch({want.cmd.name(), " found_end"}, rsp_found_end, want.found_end);
         if (rsp_in_use !== want.in_use)
            report_mismatch({want.cmd.name(), " in_use"}, 32'(rsp_in_use), 32'(want.in_use));
      end
   endtask

   // result side: random back-pressure while receiver_idles is set, check every accepted transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_result();
      rsp_ready <= !(receiver_idles && $urandom_range(0, 99) < 33);
   end

   // Called at a rising edge; returns at the edge where the transaction is taken.
   task automatic send_request(cmd_type cmd, logic [15:0] tag, logic [31:0] s,
                               logic [31:0] e, logic [31:0] q);
      if (sender_idles && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 33);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_type_tag <= tag;
      req_range_start <= s;
      req_range_end <= e;
      req_query_id <= q;
      do @(posedge clock); while (!req_ready);
      pending_results.insert(pending_results.size(), predict_map_result(cmd, tag, s, e, q));
   endtask

   task automatic wait_for_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic send_add(logic [15:0] tag, logic [31:0] s, logic [31:0] e);
      send_request(CMD_ADD, tag, s, e, $urandom);
   endtask

   task automatic send_lookup(logic [31:0] q);
      send_request(CMD_LOOKUP, 16'($urandom), $urandom, $urandom, q);
   endtask

   task automatic send_in_use(logic [15:0] tag);
      send_request(CMD_IN_USE, tag, $urandom, $urandom, $urandom);
   endtask

   task automatic send_clear;
      send_request(CMD_CLEAR, 16'($urandom), $urandom, $urandom, $urandom);
   endtask

   function automatic logic [31:0] id_in_span();
      logic [63:0] width;
      logic [63:0] offset;
      width = {32'd0, span_hi} - {32'd0, span_lo} + 64'd1;
      offset = {32'd0, $urandom} % width;
      return span_lo + offset[31:0];
   endfunction

   function automatic logic [15:0] pick_tag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35 && tbl_count != 0)
         return tbl_type[tbl_count - 1];
      else if (r < 85)
         return tag_pool[$urandom_range(0, 7)];
      return 16'($urandom);
   endfunction

   task automatic test_directed;
      send_lookup(32'd0);
      send_in_use(16'h0000);
      send_clear();
      send_add(16'h0007, 32'd10, 32'd5);               // reversed on empty table
      send_add(16'h0000, 32'd0, 32'd0);
      send_add(16'h0000, 32'd1, 32'd1);                // extends tail
      send_add(16'hFFFF, 32'd2, 32'h7FFF_FFFF);
      send_add(16'h1234, 32'd5, 32'd9);                // does not follow
      send_add(16'h1234, 32'h8000_0000, 32'h7FFF_0000); // reversed
      send_lookup(32'd0);
      send_lookup(32'd1);
      send_lookup(32'h7FFF_FFFF);
      send_lookup(32'h8000_0000);
      send_in_use(16'h0000);
      send_in_use(16'hFFFF);
      send_in_use(16'h1234);
      send_add(16'h5A5A, 32'h8000_0000, ID_MAX);
      send_add(16'h5A5A, 32'd0, 32'd0);                // id space does not wrap
      send_add(16'h5A5A, ID_MAX, ID_MAX);
      send_lookup(ID_MAX);
      send_clear();
      send_lookup(32'd0);                              // stale span, empty table
      send_in_use(16'h0000);
      send_add(16'h8001, ID_MAX, ID_MAX);
      send_lookup(ID_MAX);
      send_lookup(32'd0);
      wait_for_results();
   endtask

   task automatic test_table_full;
      logic [31:0] s;
      logic [31:0] e;
      logic [15:0] tag;
      logic [15:0] prev_tag;
      send_clear();
      s = $urandom & 32'h00FF_FFFF;
      prev_tag = 16'($urandom);
      for (int i = 0; i < MAP_DEPTH; i++) begin
         tag = 16'($urandom);
         if (tag == prev_tag)
            tag = ~tag;
         e = s + $urandom_range(0, 255);
         send_add(tag, s, e);
         prev_tag = tag;
         s = e + 32'd1;
      end
      send_add(~prev_tag, s, s + 32'd3);               // new type, no room
      send_add(prev_tag, s, s + 32'd7);                // tail grows while full
      s = s + 32'd8;
      send_add(~prev_tag, s + 32'd5, s + 32'd9);
      send_lookup(span_lo);
      send_lookup(span_hi);
      send_lookup(span_hi + 32'd1);
      repeat (12) send_lookup(id_in_span());
      send_in_use(tbl_type[0]);
      send_in_use(tbl_type[MAP_DEPTH / 2]);
      send_in_use(prev_tag);
      send_in_use(~prev_tag);
      wait_for_results();
   endtask

   task automatic test_random(int count, bit idles);
      int          r;
      logic [31:0] s;
      logic [31:0] e;
      logic [31:0] q;
      logic [63:0] e_wide;
      logic [63:0] len;
      sender_idles = idles;
      receiver_idles = idles;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (idles && $urandom_range(0, 99) == 0)
            wait_for_results();
         if (r < 3) begin
            send_clear();
         end else if (r < 48) begin
            if (tbl_count != 0 && span_hi == ID_MAX) begin
               send_clear();
            end else begin
               if (tbl_count == 0)
                  s = ($urandom_range(0, 9) == 0) ? $urandom : ($urandom & 32'h0FFF_FFFF);
               else
                  s = span_hi + 32'd1;
               r = $urandom_range(0, 99);
               if (r < 70)
                  len = 64'($urandom_range(0, 63));
               else if (r < 95)
                  len = 64'($urandom_range(0, 65535));
               else
                  len = {32'd0, $urandom};
               e_wide = {32'd0, s} + len;
               e = (e_wide > {32'd0, ID_MAX}) ? ID_MAX : e_wide[31:0];
               send_add(pick_tag(), s, e);
            end
         end else if (r < 73) begin
            r = $urandom_range(0, 99);
            if (r < 15)
               q = $urandom;
            else if (r < 20)
               q = span_lo - 32'd1;
            else if (r < 25)
               q = span_hi + 32'd1;
            else if (r < 30)
               q = span_lo;
            else if (r < 35)
               q = span_hi;
            else
               q = id_in_span();
            send_lookup(q);
         end else if (r < 85) begin
            send_in_use(pick_tag());
         end else begin
            // malformed adds: arbitrary, reversed, or leaving a hole
            case ($urandom_range(0, 2))
               0: send_add(16'($urandom), $urandom, $urandom);
               1: send_add(pick_tag(), span_hi + 32'd1, span_hi);
               default: send_add(pick_tag(), span_hi + 32'd2,
                                 span_hi + 32'd2 + $urandom_range(0, 15));
            endcase
         end
      end
      wait_for_results();
   endtask

   initial begin
      for (int i = 0; i < 8; i++)
         tag_pool[i] = 16'($urandom);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_random(150, 1'b0);
      test_random(350, 1'b1);
      wait_for_results();
      repeat (MAP_DEPTH + 40) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("tb_contiguous_id_range_map passed");
      else
         $display("tb_contiguous_id_range_map failed");
      $finish;
   end

endmodule
